### rtl/utf8_validating_decoder_unit_assert.svh
// ----------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Shared property forms for the checker of the UTF-8 validating decoder.
// ----------------------------------------------------------------------------
`ifndef UTF8_VALIDATING_DECODER_UNIT_ASSERT_SVH
`define UTF8_VALIDATING_DECODER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UTF8VD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("utf8vd check failed");

// The consequent must hold in the cycle after the antecedent.
`define UTF8VD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("utf8vd check failed");

`endif

### rtl/utf8vd_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 validating decoder package
// Types and byte constants shared by the decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8vd_pkg;

    localparam int unsigned CP_W = 21;

    typedef enum logic [2:0] {
        ERR_NONE          = 3'd0,
        ERR_BAD_LEAD      = 3'd1,
        ERR_OVERLONG_LEAD = 3'd2,
        ERR_HIGH_LEAD     = 3'd3,
        ERR_MISSING_CONT  = 3'd4,
        ERR_TRUNCATED     = 3'd5
    } t_err;

    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD2_MIN   = 8'hC0;
    localparam logic [7:0] LEAD_C1     = 8'hC1;
    localparam logic [7:0] LEAD3_MIN   = 8'hE0;
    localparam logic [7:0] LEAD4_MIN   = 8'hF0;
    localparam logic [7:0] LEAD_HIGH   = 8'hF5;
    localparam logic [7:0] LEAD_BAD    = 8'hF8;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_TAG    = 8'h80;

    typedef struct packed {
        logic [CP_W-1:0] codepoint;
        logic            cp_valid;
        t_err            error_code;
        logic            last;
    } t_result;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_buffer;
    } t_item;

endpackage

`default_nettype wire

### rtl/utf8vd_in_stage.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder input stage
// Registers one input item and holds it until the decode step takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8vd_in_stage
    import utf8vd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_stall,
    input  wire t_item i_item,
    input  wire logic  i_take,
    output logic       o_held,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_stall = r_valid && !i_take;
    assign o_held  = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

### rtl/utf8vd_step.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder step
// Holds the sequence state and decodes one byte per cycle while i_go is high; it emits a
// result only when a code point completes or an error is found.
`default_nettype none

module utf8vd_step
    import utf8vd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_go,
    input  wire t_item i_item,
    output logic       o_emit,
    output t_result    o_result
);

    logic [1:0]      r_pending;
    logic [1:0]      n_pending;
    logic [CP_W-1:0] r_partial;
    logic [CP_W-1:0] n_partial;
    logic            r_skip;
    logic            n_skip;
    logic            fail;
    t_err            fail_code;
    logic [7:0]      b;
    logic            eob;
    logic [CP_W-1:0] joined;

    assign b      = i_item.byte_in;
    assign eob    = i_item.end_of_buffer;
    assign joined = {r_partial[CP_W-7:0], b[5:0]};

    always_comb begin
        n_pending = r_pending;
        n_partial = r_partial;
        n_skip    = r_skip;
        fail      = 1'b0;
        fail_code = ERR_NONE;
        o_emit    = 1'b0;
        o_result  = '{codepoint: '0, cp_valid: 1'b0, error_code: ERR_NONE, last: eob};
        if (i_go) begin
            if (r_skip) begin
                if (eob) begin
                    n_pending = '0;
                    n_partial = '0;
                    n_skip    = 1'b0;
                end
            end else if (r_pending == 2'd0) begin
                priority if (b < ASCII_LIMIT) begin
                    n_partial          = '0;
                    o_emit             = 1'b1;
                    o_result.codepoint = CP_W'(b);
                    o_result.cp_valid  = 1'b1;
                end else if (b < LEAD2_MIN || b >= LEAD_BAD) begin
                    fail      = 1'b1;
                    fail_code = ERR_BAD_LEAD;
                end else if (b <= LEAD_C1) begin
                    fail      = 1'b1;
                    fail_code = ERR_OVERLONG_LEAD;
                end else if (b >= LEAD_HIGH) begin
                    fail      = 1'b1;
                    fail_code = ERR_HIGH_LEAD;
                end else begin
                    priority if (b < LEAD3_MIN) begin
                        n_pending = 2'd1;
                        n_partial = CP_W'(b[4:0]);
                    end else if (b < LEAD4_MIN) begin
                        n_pending = 2'd2;
                        n_partial = CP_W'(b[3:0]);
                    end else begin
                        n_pending = 2'd3;
                        n_partial = CP_W'(b[2:0]);
                    end
                    if (eob) begin
                        fail      = 1'b1;
                        fail_code = ERR_TRUNCATED;
                    end
                end
            end else if ((b & CONT_MASK) != CONT_TAG) begin
                fail      = 1'b1;
                fail_code = ERR_MISSING_CONT;
            end else if (r_pending == 2'd1) begin
                n_pending          = '0;
                n_partial          = '0;
                o_emit             = 1'b1;
                o_result.codepoint = joined;
                o_result.cp_valid  = 1'b1;
            end else begin
                n_pending = r_pending - 2'd1;
                n_partial = joined;
                if (eob) begin
                    fail      = 1'b1;
                    fail_code = ERR_TRUNCATED;
                end
            end
            if (fail) begin
                n_pending           = '0;
                n_partial           = '0;
                n_skip              = !eob;
                o_emit              = 1'b1;
                o_result.error_code = fail_code;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_partial <= '0;
            r_skip    <= 1'b0;
        end else begin
            r_pending <= n_pending;
            r_partial <= n_partial;
            r_skip    <= n_skip;
        end
    end

endmodule

`default_nettype wire

### rtl/utf8vd_out_stage.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder output stage
// Result register that holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8vd_out_stage
    import utf8vd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    output logic         o_free,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || !i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

### rtl/utf8_validating_decoder_unit.sv
// ----------------------------------------------------------------------------
// UTF-8 validating decoder
// Decodes one UTF-8 byte per item into code points and error results.
// ----------------------------------------------------------------------------
// Each byte is registered in the input stage, decoded by the step and its result registered in the output stage.
// Throughput: one byte per cycle while the receiver does not stall the output, set by the single decode step per byte.
// A byte that completes nothing, or is dropped after an error, gives no result.
// Reset is synchronous and clears the sequence state and both valid flags.
`default_nettype none

module utf8_validating_decoder_unit
    import utf8vd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_byte_in,
    input  wire logic        i_end_of_buffer,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [20:0]      o_codepoint,
    output logic             o_cp_valid,
    output logic [2:0]       o_error_code,
    output logic             o_last
);

    t_item   in_item;
    t_item   held_item;
    logic    held;
    logic    out_free;
    logic    go;
    logic    emit;
    t_result step_result;
    t_result out_result;

    assign in_item = '{byte_in: i_byte_in, end_of_buffer: i_end_of_buffer};
    assign go      = held && out_free;

    utf8vd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (in_item),
        .i_take  (out_free),
        .o_held  (held),
        .o_item  (held_item)
    );

    utf8vd_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_item   (held_item),
        .o_emit   (emit),
        .o_result (step_result)
    );

    utf8vd_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (go && emit),
        .i_result (step_result),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (out_result)
    );

    assign o_codepoint  = out_result.codepoint;
    assign o_cp_valid   = out_result.cp_valid;
    assign o_error_code = out_result.error_code;
    assign o_last       = out_result.last;

endmodule

`default_nettype wire

### rtl/utf8vd_checker.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder port checker
// Watches the ports of the decoder and checks results and handshake.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_validating_decoder_unit_assert.svh"

module utf8vd_checker
    import utf8vd_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [20:0] o_codepoint,
    input wire logic        o_cp_valid,
    input wire logic [2:0]  o_error_code,
    input wire logic        o_last
);

    `UTF8VD_ASSERT_NEXT(a_stalled_item_holds, o_valid && i_stall, o_valid && $stable({o_codepoint, o_cp_valid, o_error_code, o_last}))
    `UTF8VD_ASSERT_NOW(a_point_has_no_error, o_valid && o_cp_valid, o_error_code == ERR_NONE)
    `UTF8VD_ASSERT_NOW(a_error_has_no_point, o_valid && o_error_code != ERR_NONE, !o_cp_valid && o_codepoint == '0)
    `UTF8VD_ASSERT_NOW(a_truncated_is_last, o_valid && o_error_code == ERR_TRUNCATED, o_last)

endmodule

bind utf8_validating_decoder_unit utf8vd_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_codepoint  (o_codepoint),
    .o_cp_valid   (o_cp_valid),
    .o_error_code (o_error_code),
    .o_last       (o_last)
);

`default_nettype wire
